/* hdl/dcmb_pkg.sv */
// Shared types and constants for the dual CPU mailbox flag register block.
// No dependencies; used by every module of the block.
`default_nettype none

package dcmb_pkg;

  // Bus widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned InTdW  = 40;

  // Register selects
  localparam logic [1:0] REG_CMD  = 2'd0;
  localparam logic [1:0] REG_M2IO = 2'd1;
  localparam logic [1:0] REG_IO2M = 2'd2;
  localparam logic [1:0] REG_CTRL = 2'd3;

  // Bus sources (any other code counts as other)
  localparam logic [1:0] SRC_MAIN    = 2'd0;
  localparam logic [1:0] SRC_IO      = 2'd1;
  localparam logic [1:0] SRC_OTHER   = 2'd2;
  localparam logic [1:0] SRC_UNKNOWN = 2'd3;

  // Access command and size codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam logic SIZE_HALF = 1'b0;
  localparam logic SIZE_WORD = 1'b1;

  // Status codes
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_IGNORED = 1'b1;

  // Control word constants
  localparam logic [31:0] CTRL_RD_MAIN  = 32'hF000_0102;
  localparam logic [31:0] CTRL_RD_IO    = 32'hF000_0002;
  localparam logic [31:0] CTRL_MAIN_KEEP = 32'hFFFF_FEFF;
  localparam logic [31:0] CTRL_MAIN_BIT = 32'h0000_0100;
  localparam logic [31:0] CTRL_TOG_MASK = 32'h0000_00F0;
  localparam logic [31:0] CTRL_TRIG_LO  = 32'h0000_0020;
  localparam logic [31:0] CTRL_TRIG_HI  = 32'h0000_0080;
  localparam logic [31:0] CTRL_FLD_MASK = 32'h0000_F000;
  localparam logic [31:0] CTRL_FLD_VAL  = 32'h0000_2000;
  localparam logic [15:0] CTRL_HALF_IO  = 16'h0002;

  // One bus access
  typedef struct packed {
    logic        command;
    logic [1:0]  register_select;
    logic [1:0]  bus_source;
    logic        access_size;
    logic [1:0]  byte_offset;
    logic [31:0] write_data;
  } req_t;

  // One access result
  typedef struct packed {
    logic [31:0] read_data;
    logic        access_status;
  } rsp_t;

endpackage

`default_nettype wire

/* hdl/dcmb_in_stage.sv */
// Input register stage: captures one access beat and unpacks it.
// Depends on dcmb_pkg.
`default_nettype none

module dcmb_in_stage (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [dcmb_pkg::InTdW-1:0]   in_tdata,
  input  wire logic                         advance,
  output logic                              req_valid,
  output dcmb_pkg::req_t                    req
);

  logic           valid_r;
  logic           valid_nxt;
  dcmb_pkg::req_t req_r;

  // Stage frees up when its beat moves on
  assign in_tready = !valid_r || advance;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture, fields from the lowest bit up
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.command         <= in_tdata[0];
      req_r.register_select <= in_tdata[2:1];
      req_r.bus_source      <= in_tdata[4:3];
      req_r.access_size     <= in_tdata[5];
      req_r.byte_offset     <= in_tdata[7:6];
      req_r.write_data      <= in_tdata[39:8];
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

`default_nettype wire

/* hdl/dcmb_regbank.sv */
// Mailbox register bank: the four registers and their per-source access rules.
// Depends on dcmb_pkg.
`default_nettype none

module dcmb_regbank (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  wire dcmb_pkg::req_t req,
  output dcmb_pkg::rsp_t      rsp
);

  logic [31:0] cmd_r,  cmd_nxt;
  logic [31:0] m2io_r, m2io_nxt;
  logic [31:0] io2m_r, io2m_nxt;
  logic [31:0] ctrl_r, ctrl_nxt;

  logic        is_main;
  logic        is_io;
  logic        is_wr;
  logic        is_word;
  logic        hi_half;
  logic [31:0] wd;
  logic [31:0] half_mask;
  logic [31:0] half_data;
  logic [31:0] io_tmp;
  logic [31:0] io_ctrl;
  logic [15:0] half_rd;

  assign is_main = (req.bus_source == dcmb_pkg::SRC_MAIN);
  assign is_io   = (req.bus_source == dcmb_pkg::SRC_IO);
  assign is_wr   = (req.command == dcmb_pkg::CMD_WRITE);
  assign is_word = (req.access_size == dcmb_pkg::SIZE_WORD);
  assign hi_half = req.byte_offset[1];
  assign wd      = req.write_data;

  // Halfword lane select
  assign half_mask = hi_half ? 32'hFFFF_0000 : 32'h0000_FFFF;
  assign half_data = hi_half ? {wd[15:0], 16'h0000} : {16'h0000, wd[15:0]};

  // io-side control update; only touches the low half, so it serves halfword 0 too
  always_comb begin
    io_tmp = ctrl_r;
    if ((wd & (dcmb_pkg::CTRL_TRIG_LO | dcmb_pkg::CTRL_TRIG_HI)) != 32'h0) begin
      io_tmp = (io_tmp & ~dcmb_pkg::CTRL_FLD_MASK) | dcmb_pkg::CTRL_FLD_VAL;
    end
    if ((io_tmp & wd & dcmb_pkg::CTRL_TOG_MASK) != 32'h0) begin
      io_ctrl = io_tmp & ~(wd & dcmb_pkg::CTRL_TOG_MASK);
    end else begin
      io_ctrl = io_tmp | (wd & dcmb_pkg::CTRL_TOG_MASK);
    end
  end

  // Next register values and result
  always_comb begin
    cmd_nxt  = cmd_r;
    m2io_nxt = m2io_r;
    io2m_nxt = io2m_r;
    ctrl_nxt = ctrl_r;
    rsp.read_data     = 32'h0;
    rsp.access_status = dcmb_pkg::STAT_OK;
    half_rd = hi_half ? ctrl_r[31:16] : ctrl_r[15:0];

    if (!is_word && req.register_select != dcmb_pkg::REG_CTRL) begin
      rsp.access_status = dcmb_pkg::STAT_IGNORED;
    end else if (is_word) begin
      if (is_wr) begin
        case (req.register_select)
          dcmb_pkg::REG_CMD: begin
            if (is_main) cmd_nxt = wd;
          end
          dcmb_pkg::REG_M2IO: begin
            if (is_main)    m2io_nxt = m2io_r | wd;
            else if (is_io) m2io_nxt = m2io_r & ~wd;
            else            m2io_nxt = wd;
          end
          dcmb_pkg::REG_IO2M: begin
            if (is_io)        io2m_nxt = io2m_r | wd;
            else if (is_main) io2m_nxt = io2m_r & ~wd;
            else              io2m_nxt = wd;
          end
          default: begin
            if (is_main) begin
              ctrl_nxt = (ctrl_r & dcmb_pkg::CTRL_MAIN_KEEP) | (wd & dcmb_pkg::CTRL_MAIN_BIT);
            end else if (is_io) begin
              ctrl_nxt = io_ctrl;
            end else begin
              ctrl_nxt = wd;
            end
          end
        endcase
      end else begin
        case (req.register_select)
          dcmb_pkg::REG_CMD:  rsp.read_data = cmd_r;
          dcmb_pkg::REG_M2IO: rsp.read_data = m2io_r;
          dcmb_pkg::REG_IO2M: rsp.read_data = io2m_r;
          default: begin
            if (is_main)    rsp.read_data = ctrl_r | dcmb_pkg::CTRL_RD_MAIN;
            else if (is_io) rsp.read_data = ctrl_r | dcmb_pkg::CTRL_RD_IO;
            else            rsp.read_data = ctrl_r;
          end
        endcase
      end
    end else begin
      // halfword on the control word
      if (is_wr) begin
        if (is_io && req.byte_offset == 2'd0) begin
          ctrl_nxt = io_ctrl;
        end else begin
          ctrl_nxt = (ctrl_r & ~half_mask) | half_data;
        end
      end else begin
        if (is_io && req.byte_offset == 2'd0) begin
          rsp.read_data = {16'h0000, half_rd | dcmb_pkg::CTRL_HALF_IO};
        end else begin
          rsp.read_data = {16'h0000, half_rd};
        end
      end
    end
  end

  // Register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= 32'h0;
      m2io_r <= 32'h0;
      io2m_r <= 32'h0;
      ctrl_r <= 32'h0;
    end else if (fire) begin
      cmd_r  <= cmd_nxt;
      m2io_r <= m2io_nxt;
      io2m_r <= io2m_nxt;
      ctrl_r <= ctrl_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/dual_cpu_mailbox_flag_registers.sv */
// Mailbox register block shared by a main CPU and an io CPU.
//
// Input channel in_*: one beat is one register access (read or write, word
// or halfword) tagged with its source side. Output channel out_*: one beat
// per access carrying the read data and a status flag in out_tuser that
// marks an unsupported halfword access (ignored, data zero).
// An accepted beat is captured in the input register; when it advances,
// the register bank is read and updated as the result goes into the
// output register, which then raises out_tvalid.
// Throughput: one access per cycle while the receiver keeps taking results;
// the register update is a single read-modify-write between the input and
// output registers.
// Reset (rst_n low, synchronous) clears all four registers and drops both
// valid flags. When the receiver stalls, the result holds in the output
// register, one more access waits in the input register, and in_tready
// then falls until the output drains.
// Depends on dcmb_pkg, dcmb_in_stage and dcmb_regbank.
`default_nettype none

module dual_cpu_mailbox_flag_registers (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // [0] command, [2:1] register_select, [4:3] bus_source, [5] access_size,
  // [7:6] byte_offset, [39:8] write_data
  input  wire logic [dcmb_pkg::InTdW-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [31:0] read_data
  output logic [dcmb_pkg::DataW-1:0]       out_tdata,
  // [0] access_status
  output logic                             out_tuser
);

  logic           req_valid;
  logic           advance;
  dcmb_pkg::req_t req;
  dcmb_pkg::rsp_t rsp;
  logic           out_valid_r;
  logic           out_valid_nxt;
  dcmb_pkg::rsp_t out_r;

  // Beat moves from input register to output register
  assign advance = req_valid && (!out_valid_r || out_tready);

  dcmb_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  dcmb_regbank u_regbank (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .req   (req),
    .rsp   (rsp)
  );

  // Output register
  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.read_data;
  assign out_tuser  = out_r.access_status;

endmodule

`default_nettype wire

/* hdl/dcmb_checker.sv */
// Port-level checks for the mailbox register block, bound to the top level.
// Depends on dcmb_pkg and dual_cpu_mailbox_flag_registers.
`default_nettype none

module dcmb_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [dcmb_pkg::DataW-1:0] out_tdata,
  input wire logic                       out_tuser
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Ignored accesses return zero data
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("ignored access returned data");

  // Input only back-pressures behind a stalled output
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without output stall");

  // An accepted beat reaches the output when the output side keeps taking beats
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tready ##1 out_tready |=> out_tvalid)
    else $error("result late");

endmodule

bind dual_cpu_mailbox_flag_registers dcmb_checker u_dcmb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

/* tb/sv/dual_cpu_mailbox_flag_registers_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the dual CPU mailbox flag register block: a directed
// table then random accesses, each result checked against a predictor or fixed value.
// Depends on dcmb_pkg and dual_cpu_mailbox_flag_registers.

module dual_cpu_mailbox_flag_registers_test;

  localparam int unsigned DIR_N      = 25;
  localparam int unsigned PHASE_N    = 175;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_LEN   = 80;
  localparam int unsigned TAIL_LEN   = 8;

  // Directed stimulus row; want is used only where typed is set
  typedef struct {
    dcmb_pkg::req_t acc;
    bit             typed;
    dcmb_pkg::rsp_t want;
  } dir_row_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [dcmb_pkg::InTdW-1:0]     in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [dcmb_pkg::DataW-1:0]     out_tdata;
  logic                           out_tuser;

  // Predicted register contents
  logic [31:0] m_cmd, m_m2io, m_io2m, m_ctrl;

  dcmb_pkg::rsp_t due_results[$];
  dir_row_t       dir_tab[DIR_N];
  int unsigned    mismatches   = 0;
  int unsigned    idle_cycles  = 0;
  int unsigned    send_gap_pct = 0;
  int unsigned    recv_stall_pct = 0;
  bit             hold_req     = 1'b0;
  int unsigned    hold_left    = 0;
  logic [1:0]     last_wr_sel  = dcmb_pkg::REG_CMD;

  dual_cpu_mailbox_flag_registers dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Beat layout from bit 0 up: command, select, source, size, offset, data
  function automatic logic [dcmb_pkg::InTdW-1:0] pack_access(dcmb_pkg::req_t a);
    return {a.write_data, a.byte_offset, a.access_size, a.bus_source,
            a.register_select, a.command};
  endfunction

  // Set-on-write from one side, clear-on-write from the other, plain otherwise
  function automatic logic [31:0] flag_update(logic [31:0] cur, logic [1:0] src,
                                              logic [31:0] d, logic [1:0] set_src,
                                              logic [1:0] clr_src);
    if (src == set_src) return cur | d;
    if (src == clr_src) return cur & ~d;
    return d;
  endfunction

  // io side control write: optional field force, then toggle of bits 7:4
  function automatic logic [31:0] io_ctrl_update(logic [31:0] cur, logic [31:0] d);
    logic [31:0] tog;
    logic [31:0] nxt;
    tog = d & dcmb_pkg::CTRL_TOG_MASK;
    nxt = cur;
    if ((d & (dcmb_pkg::CTRL_TRIG_LO | dcmb_pkg::CTRL_TRIG_HI)) != '0)
      nxt = (nxt & ~dcmb_pkg::CTRL_FLD_MASK) | dcmb_pkg::CTRL_FLD_VAL;
    if ((nxt & tog) != '0) nxt = nxt & ~tog;
    else                   nxt = nxt | tog;
    return nxt;
  endfunction

  // Predict the result of one access and update the register copy
  function automatic dcmb_pkg::rsp_t mailbox_access(dcmb_pkg::req_t a);
    dcmb_pkg::rsp_t r;
    logic [15:0]    d16;
    logic [31:0]    lo;
    r.read_data     = '0;
    r.access_status = dcmb_pkg::STAT_OK;
    d16 = a.write_data[15:0];
    if (a.access_size == dcmb_pkg::SIZE_HALF && a.register_select != dcmb_pkg::REG_CTRL) begin
      r.access_status = dcmb_pkg::STAT_IGNORED;
    end else if (a.access_size == dcmb_pkg::SIZE_WORD) begin
      if (a.command == dcmb_pkg::CMD_WRITE) begin
        case (a.register_select)
          dcmb_pkg::REG_CMD:
            if (a.bus_source == dcmb_pkg::SRC_MAIN) m_cmd = a.write_data;
          dcmb_pkg::REG_M2IO:
            m_m2io = flag_update(m_m2io, a.bus_source, a.write_data,
                                 dcmb_pkg::SRC_MAIN, dcmb_pkg::SRC_IO);
          dcmb_pkg::REG_IO2M:
            m_io2m = flag_update(m_io2m, a.bus_source, a.write_data,
                                 dcmb_pkg::SRC_IO, dcmb_pkg::SRC_MAIN);
          default: begin
            if (a.bus_source == dcmb_pkg::SRC_MAIN)
              m_ctrl = (m_ctrl & dcmb_pkg::CTRL_MAIN_KEEP) |
                       (a.write_data & dcmb_pkg::CTRL_MAIN_BIT);
            else if (a.bus_source == dcmb_pkg::SRC_IO)
              m_ctrl = io_ctrl_update(m_ctrl, a.write_data);
            else
              m_ctrl = a.write_data;
          end
        endcase
      end else begin
        case (a.register_select)
          dcmb_pkg::REG_CMD:  r.read_data = m_cmd;
          dcmb_pkg::REG_M2IO: r.read_data = m_m2io;
          dcmb_pkg::REG_IO2M: r.read_data = m_io2m;
          default: begin
            r.read_data = m_ctrl;
            if (a.bus_source == dcmb_pkg::SRC_MAIN)
              r.read_data = m_ctrl | dcmb_pkg::CTRL_RD_MAIN;
            else if (a.bus_source == dcmb_pkg::SRC_IO)
              r.read_data = m_ctrl | dcmb_pkg::CTRL_RD_IO;
          end
        endcase
      end
    end else begin
      // halfword access to the control word
      if (a.command == dcmb_pkg::CMD_WRITE) begin
        if (a.bus_source == dcmb_pkg::SRC_IO && a.byte_offset == 2'd0) begin
          lo = io_ctrl_update({16'h0, m_ctrl[15:0]}, {16'h0, d16});
          m_ctrl[15:0] = lo[15:0];
        end else if (a.byte_offset[1]) begin
          m_ctrl[31:16] = d16;
        end else begin
          m_ctrl[15:0] = d16;
        end
      end else begin
        r.read_data = {16'h0, a.byte_offset[1] ? m_ctrl[31:16] : m_ctrl[15:0]};
        if (a.bus_source == dcmb_pkg::SRC_IO && a.byte_offset == 2'd0)
          r.read_data[15:0] = r.read_data[15:0] | dcmb_pkg::CTRL_HALF_IO;
      end
    end
    return r;
  endfunction

  function automatic dir_row_t row(logic cmd, logic [1:0] sel, logic [1:0] src, logic sz,
                                   logic [1:0] off, logic [31:0] d, bit typed,
                                   logic [31:0] want_rd, logic want_st);
    dir_row_t e;
    e.acc.command         = cmd;
    e.acc.register_select = sel;
    e.acc.bus_source      = src;
    e.acc.access_size     = sz;
    e.acc.byte_offset     = off;
    e.acc.write_data      = d;
    e.typed               = typed;
    e.want.read_data      = want_rd;
    e.want.access_status  = want_st;
    return e;
  endfunction

  // Data biased towards the toggle, trigger and main-side bits
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom & 32'h0000_F1F0;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom & 32'h0000_00F0;
    endcase
  endfunction

  // Mostly word accesses from the two CPUs; reads often follow up the last write
  function automatic dcmb_pkg::req_t rand_access();
    dcmb_pkg::req_t a;
    int unsigned    s;
    s = $urandom_range(0, 9);
    a.bus_source      = (s < 4) ? dcmb_pkg::SRC_MAIN :
                        (s < 8) ? dcmb_pkg::SRC_IO :
                        (s == 8) ? dcmb_pkg::SRC_OTHER : dcmb_pkg::SRC_UNKNOWN;
    a.command         = $urandom_range(0, 1) ? dcmb_pkg::CMD_WRITE : dcmb_pkg::CMD_READ;
    a.register_select = 2'($urandom_range(0, 3));
    if (a.command == dcmb_pkg::CMD_READ && $urandom_range(0, 9) < 4)
      a.register_select = last_wr_sel;
    a.access_size     = ($urandom_range(0, 3) != 0) ? dcmb_pkg::SIZE_WORD :
                                                      dcmb_pkg::SIZE_HALF;
    if (a.access_size == dcmb_pkg::SIZE_HALF && $urandom_range(0, 3) != 0)
      a.register_select = dcmb_pkg::REG_CTRL;
    a.byte_offset     = 2'($urandom_range(0, 3));
    a.write_data      = rand_word();
    if (a.command == dcmb_pkg::CMD_WRITE) last_wr_sel = a.register_select;
    return a;
  endfunction

  // Offer one beat, with random gaps beforehand, and return once it is taken
  task automatic offer(dcmb_pkg::req_t a);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_access(a);
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    dcmb_pkg::rsp_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: read_data=%h status=%b", out_tdata, out_tuser);
      end else begin
        exp_r = due_results.pop_front();
        if (out_tdata !== exp_r.read_data || out_tuser !== exp_r.access_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: read_data exp %h got %h, status exp %b got %b",
                     exp_r.read_data, out_tdata, exp_r.access_status, out_tuser);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    dcmb_pkg::req_t a;
    dcmb_pkg::rsp_t exp_r;
    m_cmd  = '0;
    m_m2io = '0;
    m_io2m = '0;
    m_ctrl = '0;
    dir_tab = '{
      // reset values and fixed status bits
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_CMD, dcmb_pkg::SRC_MAIN, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0, 1, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_MAIN, dcmb_pkg::SIZE_WORD,
          2'd1, 32'h0, 1, dcmb_pkg::CTRL_RD_MAIN, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0, 1, dcmb_pkg::CTRL_RD_IO, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_OTHER, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0, 1, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_HALF,
          2'd0, 32'h0, 1, 32'h2, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_UNKNOWN, dcmb_pkg::SIZE_HALF,
          2'd3, 32'h0, 1, 32'h0, dcmb_pkg::STAT_OK),
      // halfword on the non-control registers is ignored
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_M2IO, dcmb_pkg::SRC_MAIN, dcmb_pkg::SIZE_HALF,
          2'd2, 32'hFFFF_FFFF, 1, 32'h0, dcmb_pkg::STAT_IGNORED),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_CMD, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_HALF,
          2'd1, 32'h0, 1, 32'h0, dcmb_pkg::STAT_IGNORED),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_IO2M, dcmb_pkg::SRC_OTHER, dcmb_pkg::SIZE_HALF,
          2'd3, 32'hFFFF_FFFF, 1, 32'h0, dcmb_pkg::STAT_IGNORED),
      // command word: main only
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_CMD, dcmb_pkg::SRC_MAIN, dcmb_pkg::SIZE_WORD,
          2'd0, 32'hFFFF_FFFF, 1, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_CMD, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h1234_5678, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_CMD, dcmb_pkg::SRC_UNKNOWN, dcmb_pkg::SIZE_WORD,
          2'd2, 32'h0, 0, 32'h0, dcmb_pkg::STAT_OK),
      // flag registers: set, clear, plain
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_M2IO, dcmb_pkg::SRC_MAIN, dcmb_pkg::SIZE_WORD,
          2'd0, 32'hA5A5_A5A5, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_M2IO, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0000_FFFF, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_M2IO, dcmb_pkg::SRC_OTHER, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_IO2M, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_WORD,
          2'd0, 32'hFFFF_FFFF, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_IO2M, dcmb_pkg::SRC_MAIN, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0F0F_0F0F, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_IO2M, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0, 0, 32'h0, dcmb_pkg::STAT_OK),
      // control word: main bit 8, io toggle and field force, plain other
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_MAIN, dcmb_pkg::SIZE_WORD,
          2'd0, 32'hFFFF_FFFF, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0000_00A0, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0000_0010, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_IO, dcmb_pkg::SIZE_HALF,
          2'd0, 32'hFFFF_00F0, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_MAIN, dcmb_pkg::SIZE_HALF,
          2'd3, 32'h0000_BEEF, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_READ, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_MAIN, dcmb_pkg::SIZE_HALF,
          2'd2, 32'h0, 0, 32'h0, dcmb_pkg::STAT_OK),
      row(dcmb_pkg::CMD_WRITE, dcmb_pkg::REG_CTRL, dcmb_pkg::SRC_UNKNOWN, dcmb_pkg::SIZE_WORD,
          2'd0, 32'h0, 0, 32'h0, dcmb_pkg::STAT_OK)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int i = 0; i < DIR_N; i++) begin
      offer(dir_tab[i].acc);
      exp_r = mailbox_access(dir_tab[i].acc);
      if (dir_tab[i].typed) exp_r = dir_tab[i].want;
      due_results.push_back(exp_r);
    end

    // random phases; the first opens with a long receiver hold-off
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
        1:       begin send_gap_pct = 60; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 60; end
        default: begin send_gap_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int n = 0; n < PHASE_N; n++) begin
        a = rand_access();
        offer(a);
        due_results.push_back(mailbox_access(a));
      end
    end
    in_tvalid <= 1'b0;

    // drain, then a short tail for stray beats
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_LEN) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
